>>> hdl/random_forest_vote_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the random forest vote classifier
// Implication checks on one clock with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef RANDOM_FOREST_VOTE_CLASSIFIER_ASSERT_SVH
`define RANDOM_FOREST_VOTE_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define RFV_ASSERT_IMPLY(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define RFV_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RFV_ASSERT_IMPLY(label, clock, reset, ante, cons, msg)
`define RFV_ASSERT_NEXT(label, clock, reset, ante, cons, msg)
`endif

`endif

>>> hdl/rfv_pkg.sv
// ----------------------------------------------------------------------------
// rfv_pkg
// Shared types, field layout and request codes of the vote classifier.
// ----------------------------------------------------------------------------
package rfv_pkg;

  localparam int TREE_SEL_W   = 4;
  localparam int NODE_SEL_W   = 9;
  localparam int FEAT_SEL_W   = 3;
  localparam int VALUE_W      = 32;
  localparam int CLASS_W      = 3;
  localparam int VOTE_W       = 5;
  localparam int TREE_COUNT_W = 5;
  localparam int REQ_W        = 2;

  // Input tdata layout, lowest field first
  localparam int IN_TREE_SEL_LSB   = 0;
  localparam int IN_NODE_SEL_LSB   = IN_TREE_SEL_LSB + TREE_SEL_W;
  localparam int IN_LEFT_LSB       = IN_NODE_SEL_LSB + NODE_SEL_W;
  localparam int IN_RIGHT_LSB      = IN_LEFT_LSB + NODE_SEL_W;
  localparam int IN_SPLIT_FEAT_LSB = IN_RIGHT_LSB + NODE_SEL_W;
  localparam int IN_THR_LSB        = IN_SPLIT_FEAT_LSB + FEAT_SEL_W;
  localparam int IN_LEAF_BIT       = IN_THR_LSB + VALUE_W;
  localparam int IN_LEAF_CLASS_LSB = IN_LEAF_BIT + 1;
  localparam int IN_FEAT_SEL_LSB   = IN_LEAF_CLASS_LSB + CLASS_W;
  localparam int IN_FEAT_VAL_LSB   = IN_FEAT_SEL_LSB + FEAT_SEL_W;
  localparam int IN_USED_W         = IN_FEAT_VAL_LSB + VALUE_W;
  localparam int IN_DATA_W         = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout
  localparam int OUT_CLASS_LSB   = 0;
  localparam int OUT_VOTES_LSB   = OUT_CLASS_LSB + CLASS_W;
  localparam int OUT_OVERRUN_BIT = OUT_VOTES_LSB + VOTE_W;
  localparam int OUT_USED_W      = OUT_OVERRUN_BIT + 1;
  localparam int OUT_DATA_W      = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_NODE     = 2'd0,
    REQ_FEATURE  = 2'd1,
    REQ_CLASSIFY = 2'd2
  } req_t;

  typedef struct packed {
    logic [NODE_SEL_W-1:0]    left;
    logic [NODE_SEL_W-1:0]    right;
    logic [FEAT_SEL_W-1:0]    feat;
    logic signed [VALUE_W-1:0] thr;
    logic                     leaf;
    logic [CLASS_W-1:0]       cls;
  } rfv_node_t;

  // Outcome of one node visit
  typedef struct packed {
    logic                  leaf;
    logic [CLASS_W-1:0]    cls;
    logic [NODE_SEL_W-1:0] child;
  } rfv_step_t;

  // Command to the vote tally
  typedef struct packed {
    logic               clear;
    logic               cast;
    logic [CLASS_W-1:0] cls;
  } rfv_vote_cmd_t;

endpackage

>>> hdl/random_forest_vote_classifier.sv
// ----------------------------------------------------------------------------
// random_forest_vote_classifier
// Random forest inference: node and feature loads, tree walks, majority vote.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser carries the request kind (node write, feature
//   write, classify), tdata the request fields. Output stream (m_*): one
//   transfer per classify with the winning class, its vote count and the
//   walk overrun flag. cfg_wen/cfg_wdata write the tree count at any edge.
// Flow:
//   Node and feature writes are taken while idle. A classify walks every
//   voting tree: each visit is one read of the node memory's registered
//   read port followed by one pass through the shared split compare.
//   s_tready is low while a classify walks its trees.
// Reset: control state clears and tree_count reads zero; the node table and
//   the feature store hold whatever they held until written.
// Stall: a finished result waits in the output register; the block takes
//   new writes and a new classify meanwhile, and a second result waits in
//   the final state until the first transfer leaves.
// ----------------------------------------------------------------------------
`include "random_forest_vote_classifier_assert.svh"

module random_forest_vote_classifier #(
  parameter int MAX_TREE_COUNT = 16,
  parameter int NODES          = 512,
  parameter int FEATURE_COUNT  = 8,
  parameter int CLASS_COUNT    = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tree_sel, node_sel, left_next, right_next, split_feature,
  // split_threshold, leaf_flag, leaf_class, feature_sel, feature_value
  input  logic [rfv_pkg::IN_DATA_W-1:0]     s_tdata,
  // req_type
  input  logic [rfv_pkg::REQ_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // predicted_class, winning_votes, walk_overrun
  output logic [rfv_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_wen,
  input  logic [rfv_pkg::TREE_COUNT_W-1:0]  cfg_wdata
);

  localparam int DEPTH  = MAX_TREE_COUNT * NODES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW     = $clog2(NODES);
  localparam int FDEPTH = (FEATURE_COUNT < 8) ? FEATURE_COUNT : 8;
  localparam int CDEPTH = (CLASS_COUNT < 8) ? CLASS_COUNT : 8;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [rfv_pkg::TREE_COUNT_W-1:0] tree_count;
  logic [rfv_pkg::TREE_COUNT_W-1:0] trees, trees_lim;
  logic [rfv_pkg::TREE_COUNT_W-1:0] tree_idx, tree_idx_next;
  logic [IW-1:0]                    node_idx, node_idx_next;
  logic [IW-1:0]                    visits, visits_next;
  logic                             overrun, overrun_next;

  logic                     in_xfer;
  rfv_pkg::req_t            req;
  logic [rfv_pkg::TREE_SEL_W-1:0] tree_sel;
  logic [rfv_pkg::NODE_SEL_W-1:0] node_sel;
  rfv_pkg::rfv_node_t       wr_node;
  logic                     node_we;
  logic                     feat_we;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic                     rd_en;
  rfv_pkg::rfv_node_t       rd_node;
  rfv_pkg::rfv_step_t       step;
  rfv_pkg::rfv_vote_cmd_t   vote_cmd;
  logic [rfv_pkg::CLASS_W-1:0] best_class;
  logic [rfv_pkg::VOTE_W-1:0]  best_votes;
  logic                     out_load;
  logic                     last_tree;

  // Hold the tree count; saturate it at the table size for the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_count <= '0;
    end else if (cfg_wen) begin
      tree_count <= cfg_wdata;
    end
  end

  assign trees_lim = (32'(tree_count) > 32'(MAX_TREE_COUNT)) ?
                     rfv_pkg::TREE_COUNT_W'(MAX_TREE_COUNT) : tree_count;

  // Unpack the request
  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign req      = rfv_pkg::req_t'(s_tuser);
  assign tree_sel = s_tdata[rfv_pkg::IN_TREE_SEL_LSB +: rfv_pkg::TREE_SEL_W];
  assign node_sel = s_tdata[rfv_pkg::IN_NODE_SEL_LSB +: rfv_pkg::NODE_SEL_W];

  always_comb begin
    wr_node.left  = s_tdata[rfv_pkg::IN_LEFT_LSB +: rfv_pkg::NODE_SEL_W];
    wr_node.right = s_tdata[rfv_pkg::IN_RIGHT_LSB +: rfv_pkg::NODE_SEL_W];
    wr_node.feat  = s_tdata[rfv_pkg::IN_SPLIT_FEAT_LSB +: rfv_pkg::FEAT_SEL_W];
    wr_node.thr   = $signed(s_tdata[rfv_pkg::IN_THR_LSB +: rfv_pkg::VALUE_W]);
    wr_node.leaf  = s_tdata[rfv_pkg::IN_LEAF_BIT];
    wr_node.cls   = s_tdata[rfv_pkg::IN_LEAF_CLASS_LSB +: rfv_pkg::CLASS_W];
  end

  // Drop node writes outside the table
  assign node_we = in_xfer && (req == rfv_pkg::REQ_NODE) &&
                   (32'(tree_sel) < 32'(MAX_TREE_COUNT)) &&
                   (32'(node_sel) < 32'(NODES));
  assign feat_we = in_xfer && (req == rfv_pkg::REQ_FEATURE);
  assign wr_addr = AW'(tree_sel) * AW'(NODES) + AW'(node_sel);
  assign rd_addr = AW'(tree_idx) * AW'(NODES) + AW'(node_idx);
  assign rd_en   = (state == ST_FETCH);

  rfv_node_mem #(
    .DEPTH (DEPTH)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (wr_addr),
    .wr_data (wr_node),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_node)
  );

  rfv_split_eval #(
    .FDEPTH (FDEPTH)
  ) u_split_eval (
    .clk        (clk),
    .feat_we    (feat_we),
    .feat_sel   (s_tdata[rfv_pkg::IN_FEAT_SEL_LSB +: rfv_pkg::FEAT_SEL_W]),
    .feat_value (s_tdata[rfv_pkg::IN_FEAT_VAL_LSB +: rfv_pkg::VALUE_W]),
    .node       (rd_node),
    .step       (step)
  );

  rfv_vote_tally #(
    .CDEPTH (CDEPTH)
  ) u_vote_tally (
    .clk        (clk),
    .cmd        (vote_cmd),
    .best_class (best_class),
    .best_votes (best_votes)
  );

  assign last_tree = ((tree_idx + rfv_pkg::TREE_COUNT_W'(1)) == trees);
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Walk sequencer: fetch a node, evaluate it, then descend or move on
  always_comb begin
    state_next     = state;
    tree_idx_next  = tree_idx;
    node_idx_next  = node_idx;
    visits_next    = visits;
    overrun_next   = overrun;
    vote_cmd.clear = 1'b0;
    vote_cmd.cast  = 1'b0;
    vote_cmd.cls   = step.cls;
    case (state)
      ST_IDLE: begin
        if (in_xfer && (req == rfv_pkg::REQ_CLASSIFY)) begin
          vote_cmd.clear = 1'b1;
          overrun_next   = 1'b0;
          tree_idx_next  = '0;
          node_idx_next  = '0;
          visits_next    = '0;
          state_next     = (trees_lim == '0) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!step.leaf && (32'(step.child) < 32'(NODES)) &&
            (visits != IW'(NODES - 1))) begin
          // Descend
          node_idx_next = IW'(step.child);
          visits_next   = visits + IW'(1);
          state_next    = ST_FETCH;
        end else begin
          if (step.leaf) begin
            vote_cmd.cast = 1'b1;
          end else begin
            // Child past the table or too many visits: cut the walk off
            overrun_next = 1'b1;
          end
          node_idx_next = '0;
          visits_next   = '0;
          if (last_tree) begin
            state_next = ST_DONE;
          end else begin
            tree_idx_next = tree_idx + rfv_pkg::TREE_COUNT_W'(1);
            state_next    = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    tree_idx <= tree_idx_next;
    node_idx <= node_idx_next;
    visits   <= visits_next;
    overrun  <= overrun_next;
    if (in_xfer && (req == rfv_pkg::REQ_CLASSIFY)) begin
      trees <= trees_lim;
    end
  end

  // Output register: load on finish, drop valid once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= '0;
      m_tdata[rfv_pkg::OUT_CLASS_LSB +: rfv_pkg::CLASS_W] <= best_class;
      m_tdata[rfv_pkg::OUT_VOTES_LSB +: rfv_pkg::VOTE_W]  <= best_votes;
      m_tdata[rfv_pkg::OUT_OVERRUN_BIT]                   <= overrun;
    end
  end

  // Assertions
  `RFV_ASSERT_NEXT(a_votes_within_trees, clk, rst, out_load,
    m_tvalid && (m_tdata[rfv_pkg::OUT_VOTES_LSB +: rfv_pkg::VOTE_W] <= $past(trees)),
    "winning votes exceed the number of voting trees")

  `RFV_ASSERT_NEXT(a_busy_after_classify, clk, rst,
    in_xfer && (req == rfv_pkg::REQ_CLASSIFY), !s_tready,
    "classify accepted but input still ready")

  `RFV_ASSERT_IMPLY(a_no_votes_class_zero, clk, rst,
    m_tvalid && (m_tdata[rfv_pkg::OUT_VOTES_LSB +: rfv_pkg::VOTE_W] == '0),
    m_tdata[rfv_pkg::OUT_CLASS_LSB +: rfv_pkg::CLASS_W] == '0,
    "nonzero class reported without votes")

endmodule

>>> hdl/rfv_node_mem.sv
// ----------------------------------------------------------------------------
// rfv_node_mem
// Node table of all trees: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rfv_node_mem #(
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  rfv_pkg::rfv_node_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output rfv_pkg::rfv_node_t rd_data
);

  logic [$bits(rfv_pkg::rfv_node_t)-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rfv_pkg::rfv_node_t'(mem[rd_addr]);
    end
  end

endmodule

>>> hdl/rfv_split_eval.sv
// ----------------------------------------------------------------------------
// rfv_split_eval
// Feature store and the shared split compare that picks the next child.
// ----------------------------------------------------------------------------
module rfv_split_eval #(
  parameter int FDEPTH = 8
) (
  input  logic                          clk,
  input  logic                          feat_we,
  input  logic [rfv_pkg::FEAT_SEL_W-1:0] feat_sel,
  input  logic [rfv_pkg::VALUE_W-1:0]   feat_value,
  input  rfv_pkg::rfv_node_t            node,
  output rfv_pkg::rfv_step_t            step
);

  localparam int FIW = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;

  logic [rfv_pkg::VALUE_W-1:0] feat_q [FDEPTH];
  logic signed [rfv_pkg::VALUE_W-1:0] fv;
  logic go_left;

  always_ff @(posedge clk) begin
    if (feat_we && (32'(feat_sel) < 32'(FDEPTH))) begin
      feat_q[feat_sel[FIW-1:0]] <= feat_value;
    end
  end

  // Feature index past the store compares against zero
  always_comb begin
    fv = '0;
    if (32'(node.feat) < 32'(FDEPTH)) begin
      fv = $signed(feat_q[node.feat[FIW-1:0]]);
    end
    go_left    = (fv <= node.thr);
    step.leaf  = node.leaf;
    step.cls   = node.cls;
    step.child = go_left ? node.left : node.right;
  end

endmodule

>>> hdl/rfv_vote_tally.sv
// ----------------------------------------------------------------------------
// rfv_vote_tally
// Per-class vote counters with a running leader, lowest class on ties.
// ----------------------------------------------------------------------------
module rfv_vote_tally #(
  parameter int CDEPTH = 8
) (
  input  logic                        clk,
  input  rfv_pkg::rfv_vote_cmd_t      cmd,
  output logic [rfv_pkg::CLASS_W-1:0] best_class,
  output logic [rfv_pkg::VOTE_W-1:0]  best_votes
);

  localparam int CIW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  logic [rfv_pkg::VOTE_W-1:0] votes [CDEPTH];
  logic [rfv_pkg::VOTE_W-1:0] count_next;
  logic                       in_range;

  assign in_range   = (32'(cmd.cls) < 32'(CDEPTH));
  assign count_next = votes[cmd.cls[CIW-1:0]] + rfv_pkg::VOTE_W'(1);

  // Counts only rise, so tracking the leader per vote equals a final scan
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int i = 0; i < CDEPTH; i++) begin
        votes[i] <= '0;
      end
      best_class <= '0;
      best_votes <= '0;
    end else if (cmd.cast && in_range) begin
      votes[cmd.cls[CIW-1:0]] <= count_next;
      if ((count_next > best_votes) ||
          ((count_next == best_votes) && (cmd.cls < best_class))) begin
        best_class <= cmd.cls;
        best_votes <= count_next;
      end
    end
  end

endmodule

>>> verif/tb_random_forest_vote_classifier.sv
// ----------------------------------------------------------------------------
// tb_random_forest_vote_classifier
// Self-checking bench for the random forest vote classifier. A driver streams
// node writes, feature writes and classify requests. A shadow forest in the
// bench walks every voting tree on each accepted classify and queues the
// winning class, its vote count and the overrun flag. A monitor compares each
// output transfer with the oldest queued verdict, field by field.
// ----------------------------------------------------------------------------
module tb_random_forest_vote_classifier;

  localparam int TREE_SLOTS    = 16;
  localparam int NODE_SLOTS    = 512;
  localparam int FEATURES      = 8;
  localparam int CLASSES       = 8;
  localparam int CLK_PERIOD    = 12;
  // Lets the last write retire before a tree count change.
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int BATCH_ITEMS   = 160;
  localparam int RANDOM_PHASES = 10;
  localparam int LIMIT_CYCLES  = 1_500_000;
  // Inner nodes live below this index so walks stay short.
  localparam int INNER_SPAN    = 64;

  // Request code the block has no use for
  localparam logic [rfv_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [rfv_pkg::REQ_W-1:0]          kind;
    logic [rfv_pkg::TREE_SEL_W-1:0]     tree;
    logic [rfv_pkg::NODE_SEL_W-1:0]     node;
    logic [rfv_pkg::NODE_SEL_W-1:0]     left;
    logic [rfv_pkg::NODE_SEL_W-1:0]     right;
    logic [rfv_pkg::FEAT_SEL_W-1:0]     split_feat;
    logic signed [rfv_pkg::VALUE_W-1:0] thr;
    logic                               leaf;
    logic [rfv_pkg::CLASS_W-1:0]        cls;
    logic [rfv_pkg::FEAT_SEL_W-1:0]     feat_sel;
    logic signed [rfv_pkg::VALUE_W-1:0] feat_val;
  } forest_req_t;

  typedef struct packed {
    logic [rfv_pkg::CLASS_W-1:0] cls;
    logic [rfv_pkg::VOTE_W-1:0]  votes;
    logic                        overrun;
  } verdict_t;

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [rfv_pkg::IN_DATA_W-1:0]    s_tdata   = '0;
  logic [rfv_pkg::REQ_W-1:0]        s_tuser   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [rfv_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                             cfg_wen   = 1'b0;
  logic [rfv_pkg::TREE_COUNT_W-1:0] cfg_wdata = '0;

  // Shadow of the block: node table, feature store and tree count
  rfv_pkg::rfv_node_t                 forest_nodes [TREE_SLOTS*NODE_SLOTS];
  logic signed [rfv_pkg::VALUE_W-1:0] sample_feats [FEATURES];
  logic [rfv_pkg::TREE_COUNT_W-1:0]   voting_trees = '0;
  verdict_t                           verdict_q[$];

  // Requests waiting for the driver, and what the generator has written so far
  forest_req_t                        request_q[$];
  bit                                 node_live [TREE_SLOTS][NODE_SLOTS];
  logic signed [rfv_pkg::VALUE_W-1:0] feat_shadow [FEATURES];
  int unsigned                        offered = 0;

  int unsigned failures  = 0;
  bit          hold_kick = 1'b0;
  int unsigned hold_left = 0;

  random_forest_vote_classifier #(
    .MAX_TREE_COUNT(TREE_SLOTS),
    .NODES         (NODE_SLOTS),
    .FEATURE_COUNT (FEATURES),
    .CLASS_COUNT   (CLASSES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD/2);
    clk = 1'b1;
    #(CLK_PERIOD/2);
  end

  // --------------------------------------------------------------------------
  // Shadow forest
  // --------------------------------------------------------------------------

  // Walk each voting tree from its root and tally the leaf classes. With these
  // field widths a child, class or feature index can never fall out of range,
  // so a walk ends only at a leaf or when the visit budget runs out.
  function automatic verdict_t tally_forest();
    int unsigned                    votes [CLASSES];
    int unsigned                    trees, most, best, t, visit, c;
    logic [rfv_pkg::NODE_SEL_W-1:0] idx;
    rfv_pkg::rfv_node_t             nd;
    bit                             reached;
    verdict_t                       v;
    v.overrun = 1'b0;
    foreach (votes[i]) votes[i] = 0;
    trees = (voting_trees > TREE_SLOTS) ? TREE_SLOTS : voting_trees;
    for (t = 0; t < trees; t++) begin
      idx = '0;
      reached = 1'b0;
      for (visit = 0; visit < NODE_SLOTS && !reached; visit++) begin
        nd = forest_nodes[t*NODE_SLOTS + idx];
        if (nd.leaf) begin
          votes[nd.cls]++;
          reached = 1'b1;
        end else begin
          // less or equal goes left, signed compare
          idx = ($signed(sample_feats[nd.feat]) <= $signed(nd.thr)) ? nd.left : nd.right;
        end
      end
      if (!reached) begin
        v.overrun = 1'b1;
      end
    end
    // strict greater keeps the lowest class on a tie
    best = 0;
    most = votes[0];
    for (c = 1; c < CLASSES; c++) begin
      if (votes[c] > most) begin
        most = votes[c];
        best = c;
      end
    end
    if (most > 2**rfv_pkg::VOTE_W - 1) begin
      most = 2**rfv_pkg::VOTE_W - 1;
    end
    v.cls   = rfv_pkg::CLASS_W'(best);
    v.votes = rfv_pkg::VOTE_W'(most);
    return v;
  endfunction

  // Apply one accepted request to the shadow; a classify queues its verdict.
  function automatic void absorb_request(forest_req_t r);
    case (r.kind)
      rfv_pkg::REQ_NODE: begin
        forest_nodes[r.tree*NODE_SLOTS + r.node] =
          '{left: r.left, right: r.right, feat: r.split_feat, thr: r.thr,
            leaf: r.leaf, cls: r.cls};
      end
      rfv_pkg::REQ_FEATURE: begin
        sample_feats[r.feat_sel] = r.feat_val;
      end
      rfv_pkg::REQ_CLASSIFY: begin
        verdict_q.push_back(tally_forest());
      end
      default: begin
        // unused request code: no effect, no result
      end
    endcase
  endfunction

  function automatic logic [rfv_pkg::IN_DATA_W-1:0] pack_request(forest_req_t r);
    logic [rfv_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[rfv_pkg::IN_TREE_SEL_LSB   +: rfv_pkg::TREE_SEL_W] = r.tree;
    d[rfv_pkg::IN_NODE_SEL_LSB   +: rfv_pkg::NODE_SEL_W] = r.node;
    d[rfv_pkg::IN_LEFT_LSB       +: rfv_pkg::NODE_SEL_W] = r.left;
    d[rfv_pkg::IN_RIGHT_LSB      +: rfv_pkg::NODE_SEL_W] = r.right;
    d[rfv_pkg::IN_SPLIT_FEAT_LSB +: rfv_pkg::FEAT_SEL_W] = r.split_feat;
    d[rfv_pkg::IN_THR_LSB        +: rfv_pkg::VALUE_W]    = r.thr;
    d[rfv_pkg::IN_LEAF_BIT]                              = r.leaf;
    d[rfv_pkg::IN_LEAF_CLASS_LSB +: rfv_pkg::CLASS_W]    = r.cls;
    d[rfv_pkg::IN_FEAT_SEL_LSB   +: rfv_pkg::FEAT_SEL_W] = r.feat_sel;
    d[rfv_pkg::IN_FEAT_VAL_LSB   +: rfv_pkg::VALUE_W]    = r.feat_val;
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders. Fields a request does not use carry random bits.
  // --------------------------------------------------------------------------

  function automatic forest_req_t noise_req();
    forest_req_t r;
    r.kind       = REQ_UNUSED;
    r.tree       = rfv_pkg::TREE_SEL_W'($urandom);
    r.node       = rfv_pkg::NODE_SEL_W'($urandom);
    r.left       = rfv_pkg::NODE_SEL_W'($urandom);
    r.right      = rfv_pkg::NODE_SEL_W'($urandom);
    r.split_feat = rfv_pkg::FEAT_SEL_W'($urandom);
    r.thr        = $urandom;
    r.leaf       = 1'($urandom);
    r.cls        = rfv_pkg::CLASS_W'($urandom);
    r.feat_sel   = rfv_pkg::FEAT_SEL_W'($urandom);
    r.feat_val   = $urandom;
    return r;
  endfunction

  function automatic forest_req_t node_req(input int t, input int n, input int l,
                                           input int rt, input int f,
                                           input logic [rfv_pkg::VALUE_W-1:0] thr,
                                           input bit leaf, input int cls);
    forest_req_t r;
    r = noise_req();
    r.kind       = rfv_pkg::REQ_NODE;
    r.tree       = rfv_pkg::TREE_SEL_W'(t);
    r.node       = rfv_pkg::NODE_SEL_W'(n);
    r.left       = rfv_pkg::NODE_SEL_W'(l);
    r.right      = rfv_pkg::NODE_SEL_W'(rt);
    r.split_feat = rfv_pkg::FEAT_SEL_W'(f);
    r.thr        = thr;
    r.leaf       = leaf;
    r.cls        = rfv_pkg::CLASS_W'(cls);
    return r;
  endfunction

  function automatic forest_req_t leaf_req(input int t, input int n, input int cls);
    return node_req(t, n, $urandom, $urandom, $urandom, $urandom, 1'b1, cls);
  endfunction

  function automatic forest_req_t feature_req(input int f,
                                              input logic [rfv_pkg::VALUE_W-1:0] v);
    forest_req_t r;
    r = noise_req();
    r.kind     = rfv_pkg::REQ_FEATURE;
    r.feat_sel = rfv_pkg::FEAT_SEL_W'(f);
    r.feat_val = v;
    return r;
  endfunction

  function automatic forest_req_t classify_req();
    forest_req_t r;
    r = noise_req();
    r.kind = rfv_pkg::REQ_CLASSIFY;
    return r;
  endfunction

  function automatic logic [rfv_pkg::VALUE_W-1:0] extreme_value(input int pick);
    case (pick)
      0:       return 32'h8000_0000;  // most negative
      1:       return 32'h7FFF_FFFF;  // most positive
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;  // smallest negative step
      4:       return 32'h0001_0000;  // +1.0
      5:       return 32'hFFFF_0000;  // -1.0
      default: return 32'h0000_8000;  // +0.5
    endcase
  endfunction

  // Queue a request and track which entries the generator has filled.
  function automatic void offer(forest_req_t r);
    request_q.push_back(r);
    if (r.kind == rfv_pkg::REQ_NODE) begin
      node_live[r.tree][r.node] = 1'b1;
    end
    if (r.kind == rfv_pkg::REQ_FEATURE) begin
      feat_shadow[r.feat_sel] = r.feat_val;
    end
    if (r.kind != REQ_UNUSED) begin
      offered++;
    end
  endfunction

  // Aim thresholds at the current feature value so both branches and the
  // equal case get taken.
  function automatic logic [rfv_pkg::VALUE_W-1:0] pick_threshold(input int f);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return feat_shadow[f];
    if (r < 50) return feat_shadow[f] + 1;
    if (r < 60) return feat_shadow[f] - 1;
    if (r < 70) return extreme_value($urandom_range(0, 6));
    return $urandom;
  endfunction

  // Children always sit above their parent, so walks cannot loop. A child that
  // is not yet written gets a leaf first, so no walk reads an empty entry.
  function automatic int pick_child(input int t, input int n);
    int unsigned r, k;
    int          c;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      for (k = 0; k < 8; k++) begin
        c = $urandom_range(n + 1, NODE_SLOTS - 1);
        if (node_live[t][c]) return c;
      end
    end
    if (r < 7 && n + 1 < INNER_SPAN) begin
      c = $urandom_range(n + 1, INNER_SPAN - 1);
    end else begin
      c = $urandom_range(n + 1, NODE_SLOTS - 1);
    end
    offer(leaf_req(t, c, $urandom));
    return c;
  endfunction

  function automatic void grow_branch();
    int t, n, f, l, rt;
    t  = $urandom_range(0, TREE_SLOTS - 1);
    n  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, INNER_SPAN - 1);
    l  = pick_child(t, n);
    rt = pick_child(t, n);
    f  = $urandom_range(0, FEATURES - 1);
    offer(node_req(t, n, l, rt, f, pick_threshold(f), 1'b0, $urandom));
  endfunction

  // Point a few roots at themselves, classify, then cut them back to leaves.
  function automatic void loop_walks();
    int unsigned count, k;
    int          roots [3];
    count = $urandom_range(1, 3);
    for (k = 0; k < count; k++) begin
      roots[k] = $urandom_range(0, TREE_SLOTS - 1);
      offer(node_req(roots[k], 0, 0, 0, $urandom, $urandom, 1'b0, $urandom));
    end
    offer(classify_req());
    for (k = 0; k < count; k++) begin
      offer(leaf_req(roots[k], 0, $urandom));
    end
  endfunction

  function automatic void random_batch(input int unsigned goal);
    int unsigned target, r;
    int          f;
    target = offered + goal;
    while (offered < target) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        offer(classify_req());
      end else if (r < 60) begin
        grow_branch();
      end else if (r < 73) begin
        offer(leaf_req($urandom_range(0, TREE_SLOTS - 1), $urandom_range(0, NODE_SLOTS - 1),
                       $urandom));
      end else if (r < 85) begin
        f = $urandom_range(0, FEATURES - 1);
        offer(feature_req(f, ($urandom_range(0, 3) == 0) ? extreme_value($urandom_range(0, 6))
                                                         : $urandom));
      end else if (r < 90) begin
        offer(noise_req());
      end else if (r < 92) begin
        loop_walks();
      end else begin
        // prune a tree back to a single leaf so depth stays bounded
        offer(leaf_req($urandom_range(0, TREE_SLOTS - 1), 0, $urandom));
      end
    end
  endfunction

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued requests with random gaps; hold each one until its
  // transfer, then feed the shadow.
  // --------------------------------------------------------------------------
  forest_req_t on_wire;
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_request(on_wire);
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          s_tvalid <= 1'b0;
          send_gap--;
        end else if (request_q.size() != 0) begin
          on_wire = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= pack_request(on_wire);
          s_tuser  <= on_wire.kind;
          // switch now and then between gapless bursts and ragged traffic
          if ($urandom_range(0, 39) == 0) begin
            send_calm = !send_calm;
          end
          send_gap = send_calm ? 0 : idle_span();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: once kicked, keep the receiver off for a fixed stretch
  // so results pile up and the block stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_kick = 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls, long and short, with calm stretches between.
  int unsigned sink_stall = 0;
  bit          sink_calm  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
    end else if (sink_stall != 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 39) == 0) begin
        sink_calm = !sink_calm;
      end
      sink_stall = sink_calm ? 0 : idle_span();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check every output transfer against the oldest verdict.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.cls     = m_tdata[rfv_pkg::OUT_CLASS_LSB +: rfv_pkg::CLASS_W];
      got.votes   = m_tdata[rfv_pkg::OUT_VOTES_LSB +: rfv_pkg::VOTE_W];
      got.overrun = m_tdata[rfv_pkg::OUT_OVERRUN_BIT];
      if (verdict_q.size() == 0) begin
        $display({"%0t: result with no verdict pending: expected none, ",
                  "got class %0d votes %0d overrun %0b"},
                 $time, got.cls, got.votes, got.overrun);
        failures++;
      end else begin
        want = verdict_q.pop_front();
        if (got.cls !== want.cls) begin
          $display("%0t: predicted_class expected %0d got %0d", $time, want.cls, got.cls);
          failures++;
        end
        if (got.votes !== want.votes) begin
          $display("%0t: winning_votes expected %0d got %0d", $time, want.votes, got.votes);
          failures++;
        end
        if (got.overrun !== want.overrun) begin
          $display("%0t: walk_overrun expected %0b got %0b", $time, want.overrun, got.overrun);
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------

  // Wait until every request is through and every verdict has come back,
  // then let the last write retire.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (request_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the tree count while the block is idle.
  task automatic set_tree_count(input logic [rfv_pkg::TREE_COUNT_W-1:0] v);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    voting_trees = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  logic [rfv_pkg::TREE_COUNT_W-1:0] trees_plan [6] =
    '{5'd17, 5'd1, 5'd0, 5'd9, 5'd16, 5'd31};

  initial begin
    int k, ph;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Tree count is zero out of reset: no walks, no votes.
    offer(classify_req());
    offer(noise_req());
    // Fill every feature and every root before any walk can read them.
    for (k = 0; k < FEATURES - 1; k++) begin
      offer(feature_req(k, extreme_value(k)));
    end
    offer(feature_req(FEATURES - 1, $urandom));
    // Roots vote classes 0..3 four times each: a four-way tie.
    for (k = 0; k < TREE_SLOTS; k++) begin
      offer(leaf_req(k, 0, k % 4));
    end
    offer(classify_req());
    drain();

    set_tree_count(rfv_pkg::TREE_COUNT_W'(TREE_SLOTS));
    offer(classify_req());
    // Feature 0 is the most negative value: equal to the threshold, go left.
    offer(leaf_req(0, NODE_SLOTS - 1, 7));
    offer(leaf_req(0, 1, 6));
    offer(node_req(0, 0, NODE_SLOTS - 1, 1, 0, extreme_value(0), 1'b0, 0));
    // Feature 1 is the most positive value: above the threshold, go right.
    offer(leaf_req(1, NODE_SLOTS - 2, 4));
    offer(leaf_req(1, 2, 5));
    offer(node_req(1, 0, NODE_SLOTS - 2, 2, 1, 32'h7FFF_FFFE, 1'b0, 0));
    offer(classify_req());
    // Root pointing at itself: the walk runs out of visits and is flagged.
    offer(node_req(2, 0, 0, 0, 2, 32'h0, 1'b0, 0));
    offer(classify_req());
    offer(leaf_req(2, 0, 2));
    drain();

    // Tree count above the tree limit saturates.
    set_tree_count(5'd31);
    offer(classify_req());
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_tree_count((ph < 6) ? trees_plan[ph]
                              : rfv_pkg::TREE_COUNT_W'($urandom_range(0, 31)));
      random_batch(BATCH_ITEMS);
      // full forest voting: shut the receiver off while the sender keeps going
      if (ph == 4) begin
        hold_kick = 1'b1;
      end
      drain();
    end

    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb: failure");
    $finish;
  end

endmodule
